[hw/rtl/quaternion_to_euler_angles_core_defines.svh]
// Assertion macros for the quaternion to Euler angle core.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define QTE_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[hw/rtl/qte_pkg.sv]
// Shared constants, types and the arctangent table for the quaternion to Euler core.
package qte_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int N_ITER = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;

    localparam int QW     = 34;  // numerator / denominator terms, Q30
    localparam int XW     = 37;  // CORDIC x/y datapath
    localparam int ZW     = 27;  // angle accumulator, 1/65536 degree
    localparam int RW     = 61;  // square root radicand
    localparam int AW     = 62;  // square root remainder and root work width
    localparam int ISQ_N  = 31;  // digit steps of the square root
    localparam int SQRT_W = 31;  // root width
    localparam int OUT_W  = 16;

    localparam logic signed [QW-1:0] Q30_ONE  = QW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] DEG180   = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] DEG360   = ZW'(360 * 65536);
    localparam logic [63:0]          Q60_ONE  = 64'd1 << 60;

    // 4 front stages, square root, CORDIC prep, iterations, output stage
    localparam int LATENCY = 4 + ISQ_N + 1 + N_ITER + 1;

    typedef struct packed {
        logic signed [QW-1:0] n1;
        logic signed [QW-1:0] d1;
        logic signed [QW-1:0] n3;
        logic signed [QW-1:0] d3;
        logic signed [QW-1:0] s;
    } t_side;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_tab(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/quaternion_to_euler_angles_core.sv]
// Top level: quaternion products, asin cosine term, three CORDIC angle pipelines.
// Items pass through the front product and term stages, the 31-stage square root, the
// CORDIC prep stage, one CORDIC iteration per stage and the output stage.
// Throughput: one item per cycle; busy is never raised and o_done is a one-cycle strobe.
// Reset (synchronous, active low) clears all valid bits; items in flight are dropped.
`include "quaternion_to_euler_angles_core_defines.svh"

module quaternion_to_euler_angles_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [15:0]               i_quat_w,
    input  logic signed [15:0]               i_quat_x,
    input  logic signed [15:0]               i_quat_y,
    input  logic signed [15:0]               i_quat_z,
    output logic                             o_done,
    output logic [qte_pkg::OUT_W-1:0]        o_angle_about_x,
    output logic [qte_pkg::OUT_W-1:0]        o_angle_about_y,
    output logic [qte_pkg::OUT_W-1:0]        o_angle_about_z
);
    import qte_pkg::*;

    assign busy = 1'b0;

    // stage 1: products, Q2.30
    logic               r_v1;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_zz, r_wz, r_xy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wx <= i_quat_w * i_quat_x;
        r_yz <= i_quat_y * i_quat_z;
        r_xx <= i_quat_x * i_quat_x;
        r_yy <= i_quat_y * i_quat_y;
        r_wy <= i_quat_w * i_quat_y;
        r_zx <= i_quat_z * i_quat_x;
        r_zz <= i_quat_z * i_quat_z;
        r_wz <= i_quat_w * i_quat_z;
        r_xy <= i_quat_x * i_quat_y;
    end

    // stage 2: numerators, denominators, clamped asin argument
    logic                 r_v2;
    t_side                r_side2;
    logic signed [QW-1:0] s_raw;

    assign s_raw = -((QW'(r_wy) - QW'(r_zx)) <<< 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side2.n1 <= -((QW'(r_wx) + QW'(r_yz)) <<< 1);
        r_side2.d1 <= Q30_ONE - ((QW'(r_xx) + QW'(r_yy)) <<< 1);
        r_side2.n3 <= (QW'(r_wz) + QW'(r_xy)) <<< 1;
        r_side2.d3 <= Q30_ONE - ((QW'(r_yy) + QW'(r_zz)) <<< 1);
        if (s_raw > Q30_ONE) begin
            r_side2.s <= Q30_ONE;
        end else if (s_raw < -Q30_ONE) begin
            r_side2.s <= -Q30_ONE;
        end else begin
            r_side2.s <= s_raw;
        end
    end

    // stage 3: s squared
    logic               r_v3;
    t_side              r_side3;
    logic [63:0]        r_sq;
    logic signed [31:0] s32;

    assign s32 = $signed(r_side2.s[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq    <= 64'(s32 * s32);
        r_side3 <= r_side2;
    end

    // stage 4: radicand 1 - s^2 in Q60
    logic          r_v4;
    t_side         r_side4;
    logic [RW-1:0] r_rad;
    logic [63:0]   rad_full;

    assign rad_full = Q60_ONE - r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad   <= rad_full[RW-1:0];
        r_side4 <= r_side3;
    end

    // square root, terms travel alongside
    logic              sq_valid;
    logic [SQRT_W-1:0] sq_root;
    t_side             sq_side;

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_rad   (r_rad),
        .i_side  (r_side4),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic signed [QW-1:0] cos_term;
    assign cos_term = $signed(QW'(sq_root));

    logic vx, vy, vz;

    qte_cordic u_cordic_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_num   (sq_side.n1),
        .i_den   (sq_side.d1),
        .o_valid (vx),
        .o_angle (o_angle_about_x)
    );

    qte_cordic u_cordic_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_num   (sq_side.s),
        .i_den   (cos_term),
        .o_valid (vy),
        .o_angle (o_angle_about_y)
    );

    qte_cordic u_cordic_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_num   (sq_side.n3),
        .i_den   (sq_side.d3),
        .o_valid (vz),
        .o_angle (o_angle_about_z)
    );

    assign o_done = vx;

    `QTE_ASSERT_DLY(a_latency, start && !busy, LATENCY, o_done, "item did not complete on time")
    `QTE_ASSERT_IMP(a_lanes_agree, 1'b1, (vx == vy) && (vy == vz), "angle lanes out of step")
    `QTE_ASSERT_IMP(a_range_y, o_done, o_angle_about_y <= 16'd46080, "asin angle out of range")

endmodule

[hw/rtl/qte_isqrt.sv]
// Pipelined digit-by-digit integer square root, one result bit per stage.
module qte_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [qte_pkg::RW-1:0]     i_rad,
    input  qte_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [qte_pkg::SQRT_W-1:0] o_root,
    output qte_pkg::t_side             o_side
);
    import qte_pkg::*;

    logic          r_vld  [0:ISQ_N-1];
    logic [AW-1:0] r_rem  [0:ISQ_N-1];
    logic [AW-1:0] r_res  [0:ISQ_N-1];
    t_side         r_side [0:ISQ_N-1];

    for (genvar k = 0; k < ISQ_N; k++) begin : g_step
        localparam logic [AW-1:0] BIT = AW'(1) << (2 * (ISQ_N - 1 - k));
        logic          p_vld;
        logic [AW-1:0] p_rem;
        logic [AW-1:0] p_res;
        t_side         p_side;
        logic [AW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = AW'(i_rad);
            assign p_res  = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_res  = r_res[k-1];
            assign p_side = r_side[k-1];
        end

        assign trial = p_res + BIT;
        assign take  = (p_rem >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? (p_rem - trial) : p_rem;
            r_res[k]  <= take ? ((p_res >> 1) + BIT) : (p_res >> 1);
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_vld[ISQ_N-1];
    assign o_root  = r_res[ISQ_N-1][SQRT_W-1:0];
    assign o_side  = r_side[ISQ_N-1];

endmodule

[hw/rtl/qte_cordic.sv]
// Pipelined vectoring CORDIC: atan2 in degrees, offset, clamped and rounded.
module qte_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [qte_pkg::QW-1:0]  i_num,
    input  logic signed [qte_pkg::QW-1:0]  i_den,
    output logic                           o_valid,
    output logic [qte_pkg::OUT_W-1:0]      o_angle
);
    import qte_pkg::*;

    // prep stage
    logic                 r_pv;
    logic                 r_pzero;
    logic signed [XW-1:0] r_px;
    logic signed [XW-1:0] r_py;
    logic signed [ZW-1:0] r_pz;

    logic signed [XW-1:0] num_x;
    logic signed [XW-1:0] den_x;

    assign num_x = XW'(i_num);
    assign den_x = XW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_valid;
        end
    end

    // negative denominator: pre-rotate by 180 degrees
    always_ff @(posedge i_clk) begin
        r_pzero <= (i_num == '0) && (i_den == '0);
        if (i_den < 0) begin
            r_px <= -den_x;
            r_py <= -num_x;
            r_pz <= (i_num >= 0) ? DEG180 : -DEG180;
        end else begin
            r_px <= den_x;
            r_py <= num_x;
            r_pz <= '0;
        end
    end

    logic                 r_v    [0:N_ITER-1];
    logic                 r_zero [0:N_ITER-1];
    logic signed [XW-1:0] r_x    [0:N_ITER-1];
    logic signed [XW-1:0] r_y    [0:N_ITER-1];
    logic signed [ZW-1:0] r_z    [0:N_ITER-1];

    for (genvar k = 0; k < N_ITER; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ANG = atan_tab(k);
        logic                 p_v;
        logic                 p_zero;
        logic signed [XW-1:0] p_x;
        logic signed [XW-1:0] p_y;
        logic signed [ZW-1:0] p_z;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        if (k == 0) begin : g_first
            assign p_v    = r_pv;
            assign p_zero = r_pzero;
            assign p_x    = r_px;
            assign p_y    = r_py;
            assign p_z    = r_pz;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_zero = r_zero[k-1];
            assign p_x    = r_x[k-1];
            assign p_y    = r_y[k-1];
            assign p_z    = r_z[k-1];
        end

        assign xs = p_x >>> k;
        assign ys = p_y >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        // clockwise when y is non-negative
        always_ff @(posedge i_clk) begin
            r_zero[k] <= p_zero;
            if (!p_y[XW-1]) begin
                r_x[k] <= p_x + ys;
                r_y[k] <= p_y - xs;
                r_z[k] <= p_z + ANG;
            end else begin
                r_x[k] <= p_x - ys;
                r_y[k] <= p_y + xs;
                r_z[k] <= p_z - ANG;
            end
        end
    end

    // output: +180 degrees, clamp to [0, 360], round to 1/128 degree
    logic signed [ZW-1:0] z_fin;
    logic signed [ZW:0]   t_off;
    logic [ZW-1:0]        t_clamp;
    logic [ZW:0]          t_rnd;
    logic                 r_ov;
    logic [OUT_W-1:0]     r_angle;

    assign z_fin = r_zero[N_ITER-1] ? '0 : r_z[N_ITER-1];
    assign t_off = (ZW+1)'(z_fin) + (ZW+1)'(DEG180);

    always_comb begin
        if (t_off < 0) begin
            t_clamp = '0;
        end else if (t_off > (ZW+1)'(DEG360)) begin
            t_clamp = DEG360;
        end else begin
            t_clamp = t_off[ZW-1:0];
        end
    end

    assign t_rnd = {1'b0, t_clamp} + (ZW+1)'(256);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[N_ITER-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= t_rnd[OUT_W+8:9];
    end

    assign o_valid = r_ov;
    assign o_angle = r_angle;

endmodule
